[rtl/core/amcf_pkg.sv]
`timescale 1ns / 1ps

package amcf_pkg;

    // Player configuration
    localparam int unsigned TRACK_COUNT = 8;
    localparam int unsigned QDEPTH      = 2;
    localparam int unsigned QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

    // Request codes
    localparam logic [2:0] REQ_INIT     = 3'd0;
    localparam logic [2:0] REQ_PLAY     = 3'd1;
    localparam logic [2:0] REQ_STOP     = 3'd2;
    localparam logic [2:0] REQ_SET_VOL  = 3'd3;
    localparam logic [2:0] REQ_VOL_UP   = 3'd4;
    localparam logic [2:0] REQ_VOL_DOWN = 3'd5;
    localparam logic [2:0] REQ_NEXT     = 3'd6;
    localparam logic [2:0] REQ_PREV     = 3'd7;

    // Command codes
    localparam logic [7:0] CMD_PLAY   = 8'h03;
    localparam logic [7:0] CMD_VOLUME = 8'h06;
    localparam logic [7:0] CMD_STOP   = 8'h16;
    localparam logic [7:0] CMD_RESET  = 8'h3F;

    // Fixed frame bytes
    localparam logic [7:0]  BYTE_START   = 8'h7E;
    localparam logic [7:0]  BYTE_VERSION = 8'hFF;
    localparam logic [7:0]  BYTE_LENGTH  = 8'h06;
    localparam logic [7:0]  BYTE_FEEDBK  = 8'h00;
    localparam logic [7:0]  BYTE_P1      = 8'h00;
    localparam logic [7:0]  BYTE_END     = 8'hEF;
    localparam logic [15:0] SUM_FIXED    = 16'(BYTE_VERSION) + 16'(BYTE_LENGTH)
                                         + 16'(BYTE_FEEDBK) + 16'(BYTE_P1);

    // Byte positions within a frame
    localparam logic [3:0] POS_START   = 4'd0;
    localparam logic [3:0] POS_VERSION = 4'd1;
    localparam logic [3:0] POS_LENGTH  = 4'd2;
    localparam logic [3:0] POS_CMD     = 4'd3;
    localparam logic [3:0] POS_FEEDBK  = 4'd4;
    localparam logic [3:0] POS_P1      = 4'd5;
    localparam logic [3:0] POS_P2      = 4'd6;
    localparam logic [3:0] POS_CHK_HI  = 4'd7;
    localparam logic [3:0] POS_CHK_LO  = 4'd8;
    localparam logic [3:0] POS_END     = 4'd9;

    // Volume limits
    localparam logic [4:0] VOL_MAX  = 5'd30;
    localparam logic [4:0] VOL_STEP = 5'd5;
    localparam logic [4:0] VOL_INIT = 5'd15;

    // One queued request: first frame command and p2, follow-up flag, track and volume
    typedef struct packed {
        logic       dbl;
        logic [7:0] cmd;
        logic [7:0] p2;
        logic [3:0] track;
        logic [4:0] volume;
    } desc_t;

endpackage

[rtl/core/audio_module_command_framer_unit.sv]
`timescale 1ns / 1ps

// Audio module command framer.
// Input channel (in_valid / in_stall): one player request per transaction,
// fields req_type, track_number, volume_level. The request updates the
// track, volume and stop state at once and is queued for framing.
// Output channel (out_valid / out_stall): one frame byte per transaction,
// 7E FF 06 cmd 00 p1 p2 chkH chkL EF, with frame_end on the EF byte, last
// on the final byte of the request, and the track and volume after it.
// Init gives two frames (20 bytes); most requests give one (10 bytes);
// an out-of-range play while not stopped and previous from track 0 give none.
// The request passes through the queue and the output register before its
// first byte appears. The single-byte serializer gives one byte per cycle
// while the output is not stalled; a two-entry request queue lets the input
// take new requests while bytes go out.
// in_stall rises only when the queue is full. A stalled output holds its
// byte and the serializer waits. Reset clears state, queue and out_valid.
module audio_module_command_framer_unit import amcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] req_type,
    input  logic [7:0] track_number,
    input  logic [7:0] volume_level,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] tx_byte,
    output logic       frame_end,
    output logic       last,
    output logic [3:0] track_now,
    output logic [4:0] volume_now
);

    logic  push;
    desc_t push_desc;
    logic  pop;
    desc_t head;
    logic  empty;
    logic  full;

    amcf_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .track_number (track_number),
        .volume_level (volume_level),
        .q_full       (full),
        .push         (push),
        .push_desc    (push_desc)
    );

    amcf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    amcf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_byte    (tx_byte),
        .frame_end  (frame_end),
        .last       (last),
        .track_now  (track_now),
        .volume_now (volume_now)
    );

endmodule

[rtl/core/amcf_front.sv]
`timescale 1ns / 1ps

module amcf_front import amcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] req_type,
    input  logic [7:0] track_number,
    input  logic [7:0] volume_level,
    input  logic       q_full,
    output logic       push,
    output desc_t      push_desc
);

    logic [3:0] track_reg, track_next;
    logic [4:0] volume_reg, volume_next;
    logic       stopped_reg, stopped_next;
    logic [3:0] resume_reg, resume_next;

    logic       accept;
    logic       emit;
    logic       play_call;
    logic [7:0] play_trk;
    logic [5:0] vol_up_sum;

    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign vol_up_sum = {1'b0, volume_reg} + {1'b0, VOL_STEP};

    // Classify request and work out the new player state
    always_comb
    begin
        track_next   = track_reg;
        volume_next  = volume_reg;
        stopped_next = stopped_reg;
        resume_next  = resume_reg;
        emit         = 1'b0;
        play_call    = 1'b0;
        play_trk     = track_number;
        push_desc    = '0;

        case (req_type)
            REQ_INIT:
            begin
                volume_next   = VOL_INIT;
                emit          = 1'b1;
                push_desc.dbl = 1'b1;
                push_desc.cmd = CMD_RESET;
                push_desc.p2  = 8'h00;
            end
            REQ_PLAY:
            begin
                play_call = 1'b1;
                play_trk  = track_number;
            end
            REQ_STOP:
            begin
                resume_next   = track_reg;
                stopped_next  = 1'b1;
                emit          = 1'b1;
                push_desc.cmd = CMD_STOP;
                push_desc.p2  = 8'h00;
            end
            REQ_SET_VOL:
            begin
                volume_next   = (volume_level > {3'b000, VOL_MAX}) ? VOL_MAX
                                                                   : volume_level[4:0];
                emit          = 1'b1;
                push_desc.cmd = CMD_VOLUME;
            end
            REQ_VOL_UP:
            begin
                volume_next   = (vol_up_sum > {1'b0, VOL_MAX}) ? VOL_MAX : vol_up_sum[4:0];
                emit          = 1'b1;
                push_desc.cmd = CMD_VOLUME;
            end
            REQ_VOL_DOWN:
            begin
                volume_next   = (volume_reg >= VOL_STEP) ? (volume_reg - VOL_STEP) : 5'd0;
                emit          = 1'b1;
                push_desc.cmd = CMD_VOLUME;
            end
            REQ_NEXT:
            begin
                if (track_reg < 4'(TRACK_COUNT))
                begin
                    play_call = 1'b1;
                    play_trk  = {4'd0, 4'(track_reg + 4'd1)};
                end
                else if (track_reg == 4'(TRACK_COUNT))
                begin
                    play_call = 1'b1;
                    play_trk  = 8'd1;
                end
            end
            REQ_PREV:
            begin
                if (track_reg > 4'd1)
                begin
                    play_call = 1'b1;
                    play_trk  = {4'd0, 4'(track_reg - 4'd1)};
                end
                else if (track_reg == 4'd1)
                begin
                    play_call = 1'b1;
                    play_trk  = 8'(TRACK_COUNT);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // Play: resume when stopped, otherwise only an in-range track
        if (play_call)
        begin
            push_desc.cmd = CMD_PLAY;
            if (stopped_reg)
            begin
                track_next   = resume_reg;
                stopped_next = 1'b0;
                emit         = 1'b1;
            end
            else if (play_trk >= 8'd1 && play_trk <= 8'(TRACK_COUNT))
            begin
                track_next = play_trk[3:0];
                emit       = 1'b1;
            end
        end

        if (req_type == REQ_PLAY || req_type == REQ_NEXT || req_type == REQ_PREV)
            push_desc.p2 = {4'd0, track_next};
        else if (req_type == REQ_SET_VOL || req_type == REQ_VOL_UP
                 || req_type == REQ_VOL_DOWN)
            push_desc.p2 = {3'd0, volume_next};

        push_desc.track  = track_next;
        push_desc.volume = volume_next;
    end

    assign push = accept && emit;

    // Player state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg   <= '0;
            volume_reg  <= '0;
            stopped_reg <= 1'b0;
            resume_reg  <= '0;
        end
        else if (accept)
        begin
            track_reg   <= track_next;
            volume_reg  <= volume_next;
            stopped_reg <= stopped_next;
            resume_reg  <= resume_next;
        end
    end

endmodule

[rtl/core/amcf_queue.sv]
`timescale 1ns / 1ps

module amcf_queue import amcf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output desc_t head,
    output logic  empty,
    output logic  full
);

    desc_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> count_reg == QCNT_W'(QDEPTH))
        else $error("queue lost entries while full");

endmodule

[rtl/core/amcf_back.sv]
`timescale 1ns / 1ps

module amcf_back import amcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  desc_t      head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] tx_byte,
    output logic       frame_end,
    output logic       last,
    output logic [3:0] track_now,
    output logic [4:0] volume_now
);

    logic [3:0]  idx_reg, idx_next;
    logic        second_reg, second_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg;
    logic        fend_reg;
    logic        last_reg;
    logic [3:0]  track_reg;
    logic [4:0]  volume_reg;

    logic        advance;
    logic [7:0]  cur_cmd;
    logic [7:0]  cur_p2;
    logic [15:0] sum;
    logic [15:0] chk;
    logic [7:0]  cur_byte;
    logic        at_end;
    logic        is_last;

    assign advance = !empty && (!valid_reg || !out_stall);

    // Current frame contents and checksum
    assign cur_cmd = second_reg ? CMD_VOLUME : head.cmd;
    assign cur_p2  = second_reg ? {3'd0, VOL_INIT} : head.p2;
    assign sum     = SUM_FIXED + {8'd0, cur_cmd} + {8'd0, cur_p2};
    assign chk     = (~sum) + 16'd1;
    assign at_end  = (idx_reg == POS_END);
    assign is_last = at_end && (second_reg || !head.dbl);
    assign pop     = advance && is_last;

    // Byte select
    always_comb
    begin
        case (idx_reg)
            POS_START:   cur_byte = BYTE_START;
            POS_VERSION: cur_byte = BYTE_VERSION;
            POS_LENGTH:  cur_byte = BYTE_LENGTH;
            POS_CMD:     cur_byte = cur_cmd;
            POS_FEEDBK:  cur_byte = BYTE_FEEDBK;
            POS_P1:      cur_byte = BYTE_P1;
            POS_P2:      cur_byte = cur_p2;
            POS_CHK_HI:  cur_byte = chk[15:8];
            POS_CHK_LO:  cur_byte = chk[7:0];
            POS_END:     cur_byte = BYTE_END;
            default:     cur_byte = BYTE_END;
        endcase
    end

    // Sequencer
    always_comb
    begin
        idx_next    = idx_reg;
        second_next = second_reg;
        valid_next  = valid_reg && out_stall;
        if (advance)
        begin
            valid_next = 1'b1;
            if (at_end)
            begin
                idx_next    = POS_START;
                second_next = !is_last;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= POS_START;
            second_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            second_reg <= second_next;
            valid_reg  <= valid_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg   <= cur_byte;
            fend_reg   <= at_end;
            last_reg   <= is_last;
            track_reg  <= head.track;
            volume_reg <= head.volume;
        end
    end

    assign out_valid  = valid_reg;
    assign tx_byte    = byte_reg;
    assign frame_end  = fend_reg;
    assign last       = last_reg;
    assign track_now  = track_reg;
    assign volume_now = volume_reg;

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && last_reg |-> fend_reg)
        else $error("request ended mid frame");

    a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && fend_reg |-> byte_reg == BYTE_END)
        else $error("frame end without end byte");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= POS_END)
        else $error("byte index out of range");

    a_second_wait: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> !empty && head.dbl)
        else $error("follow-up frame without a double request");

endmodule

[tb/audio_module_command_framer_unit_test.sv]
`timescale 1ns / 1ps

module audio_module_command_framer_unit_test;
    import amcf_pkg::*;

    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;

    // One expected output byte with its side fields
    typedef struct {
        logic [7:0] data;
        logic       fend;
        logic       lst;
        logic [3:0] trk;
        logic [4:0] vol;
    } frame_byte_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] req_type;
    logic [7:0] track_number;
    logic [7:0] volume_level;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       last;
    logic [3:0] track_now;
    logic [4:0] volume_now;

    // Player state as predicted from accepted requests
    logic [3:0] pl_track;
    logic [4:0] pl_volume;
    logic       pl_stopped;
    logic [3:0] pl_resume;

    frame_byte_t pending_bytes[$];
    int          errors;

    // Sender and receiver idling knobs
    int burst_left;
    int max_gap;
    int stall_pct;
    int stall_run_max;
    int holdoff_cycles;

    audio_module_command_framer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .track_number (track_number),
        .volume_level (volume_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_byte      (tx_byte),
        .frame_end    (frame_end),
        .last         (last),
        .track_now    (track_now),
        .volume_now   (volume_now)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #(2_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // Update player state for one request and queue the frame bytes it sends
    function automatic void predict_frames(logic [2:0] rq, logic [7:0] trk_in,
                                           logic [7:0] lvl_in);
        logic [7:0]  cmd_list [2];
        logic [7:0]  p2_list [2];
        logic [7:0]  fb [10];
        logic [15:0] chk;
        int          n_frames;
        int          vol_calc;
        int          target;
        bit          want_play;
        frame_byte_t fbyte;
        n_frames  = 0;
        want_play = 1'b0;
        target    = 0;
        vol_calc  = -1;
        case (rq)
            REQ_INIT:
            begin
                cmd_list[0] = CMD_RESET;
                p2_list[0]  = 8'h00;
                n_frames    = 1;
                vol_calc    = int'(VOL_INIT);
            end
            REQ_PLAY:
            begin
                want_play = 1'b1;
                target    = int'(trk_in);
            end
            REQ_STOP:
            begin
                pl_resume   = pl_track;
                pl_stopped  = 1'b1;
                cmd_list[0] = CMD_STOP;
                p2_list[0]  = 8'h00;
                n_frames    = 1;
            end
            REQ_SET_VOL:  vol_calc = int'(lvl_in);
            REQ_VOL_UP:   vol_calc = int'(pl_volume) + int'(VOL_STEP);
            REQ_VOL_DOWN:
                vol_calc = (pl_volume >= VOL_STEP) ? int'(pl_volume) - int'(VOL_STEP) : 0;
            REQ_NEXT:
            begin
                if (int'(pl_track) < TRACK_COUNT)
                begin
                    want_play = 1'b1;
                    target    = int'(pl_track) + 1;
                end
                else if (int'(pl_track) == TRACK_COUNT)
                begin
                    want_play = 1'b1;
                    target    = 1;
                end
            end
            REQ_PREV:
            begin
                if (pl_track > 4'd1)
                begin
                    want_play = 1'b1;
                    target    = int'(pl_track) - 1;
                end
                else if (pl_track == 4'd1)
                begin
                    want_play = 1'b1;
                    target    = TRACK_COUNT;
                end
            end
            default: ;
        endcase

        // Volume requests saturate at the top
        if (vol_calc >= 0)
        begin
            pl_volume = (vol_calc > int'(VOL_MAX)) ? VOL_MAX : vol_calc[4:0];
            cmd_list[n_frames] = CMD_VOLUME;
            p2_list[n_frames]  = {3'b000, pl_volume};
            n_frames++;
        end

        // Play: resume after a stop, otherwise only a track in range
        if (want_play)
        begin
            if (pl_stopped)
            begin
                pl_track   = pl_resume;
                pl_stopped = 1'b0;
                cmd_list[n_frames] = CMD_PLAY;
                p2_list[n_frames]  = {4'h0, pl_track};
                n_frames++;
            end
            else if (target >= 1 && target <= TRACK_COUNT)
            begin
                pl_track = target[3:0];
                cmd_list[n_frames] = CMD_PLAY;
                p2_list[n_frames]  = {4'h0, pl_track};
                n_frames++;
            end
        end

        // Build the frames, checksum is the negated sum of bytes 1..6
        for (int f = 0; f < n_frames; f++)
        begin
            chk = 16'h0000 - (16'(BYTE_VERSION) + 16'(BYTE_LENGTH) + 16'(cmd_list[f])
                            + 16'(BYTE_FEEDBK) + 16'(BYTE_P1) + 16'(p2_list[f]));
            fb[0] = BYTE_START;
            fb[1] = BYTE_VERSION;
            fb[2] = BYTE_LENGTH;
            fb[3] = cmd_list[f];
            fb[4] = BYTE_FEEDBK;
            fb[5] = BYTE_P1;
            fb[6] = p2_list[f];
            fb[7] = chk[15:8];
            fb[8] = chk[7:0];
            fb[9] = BYTE_END;
            for (int b = 0; b < 10; b++)
            begin
                fbyte.data = fb[b];
                fbyte.fend = (b == 9);
                fbyte.lst  = (b == 9) && (f == n_frames - 1);
                fbyte.trk  = pl_track;
                fbyte.vol  = pl_volume;
                pending_bytes.push_back(fbyte);
            end
        end
    endfunction

    // Offer one request; bursts of back-to-back transactions, random gaps between
    task automatic send_request(logic [2:0] rq, logic [7:0] trk, logic [7:0] lvl);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        req_type     <= rq;
        track_number <= trk;
        volume_level <= lvl;
        do
            @(posedge clk);
        while (in_stall);
        predict_frames(rq, trk, lvl);
        burst_left--;
    endtask

    // Random request, mostly valid player traffic with some out-of-range noise
    task automatic random_request();
        logic [2:0] rq;
        logic [7:0] trk;
        logic [7:0] lvl;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            rq = REQ_INIT;
        else if (pick < 30)
            rq = REQ_PLAY;
        else if (pick < 40)
            rq = REQ_STOP;
        else if (pick < 52)
            rq = REQ_SET_VOL;
        else if (pick < 62)
            rq = REQ_VOL_UP;
        else if (pick < 72)
            rq = REQ_VOL_DOWN;
        else if (pick < 86)
            rq = REQ_NEXT;
        else
            rq = REQ_PREV;
        pick = $urandom_range(0, 9);
        if (pick < 8)
            trk = 8'($urandom_range(1, TRACK_COUNT));
        else if (pick == 8)
            trk = 8'($urandom_range(0, 15));
        else
            trk = 8'($urandom_range(0, 255));
        lvl = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 35))
                                          : 8'($urandom_range(0, 255));
        send_request(rq, trk, lvl);
    endtask

    // Extremes of every field and each special behavior of the player
    task automatic test_directed_requests();
        max_gap   = 0;
        stall_pct = 0;
        send_request(REQ_PLAY,     8'd0,   8'd0);    // out of range: nothing
        send_request(REQ_PLAY,     8'd9,   8'd0);    // just above the track count
        send_request(REQ_PLAY,     8'd255, 8'd255);
        send_request(REQ_PREV,     8'd0,   8'd0);    // previous from track 0: nothing
        send_request(REQ_STOP,     8'd0,   8'd0);    // stop before any play
        send_request(REQ_PLAY,     8'd5,   8'd0);    // resume of track 0, number ignored
        send_request(REQ_INIT,     8'd255, 8'd255);  // two frames
        send_request(REQ_SET_VOL,  8'd0,   8'd0);
        send_request(REQ_VOL_DOWN, 8'd0,   8'd0);    // floor at 0
        send_request(REQ_SET_VOL,  8'd0,   8'd3);
        send_request(REQ_VOL_DOWN, 8'd0,   8'd0);    // 3 down clamps to 0
        send_request(REQ_SET_VOL,  8'd0,   8'd30);
        send_request(REQ_VOL_UP,   8'd0,   8'd0);    // ceiling at 30
        send_request(REQ_SET_VOL,  8'd0,   8'd31);
        send_request(REQ_SET_VOL,  8'd0,   8'd255);
        send_request(REQ_SET_VOL,  8'd0,   8'd27);
        send_request(REQ_VOL_UP,   8'd0,   8'd0);
        send_request(REQ_PLAY,     8'd8,   8'd0);
        send_request(REQ_NEXT,     8'd0,   8'd0);    // wrap 8 -> 1
        send_request(REQ_PREV,     8'd0,   8'd0);    // wrap 1 -> 8
        send_request(REQ_PREV,     8'd0,   8'd0);
        send_request(REQ_PLAY,     8'd1,   8'd0);
        send_request(REQ_STOP,     8'd0,   8'd0);
        send_request(REQ_NEXT,     8'd0,   8'd0);    // next while stopped resumes
        send_request(REQ_STOP,     8'd0,   8'd0);
        send_request(REQ_PREV,     8'd0,   8'd0);    // previous while stopped resumes
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_output_holdoff();
        max_gap = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        holdoff_cycles = 250;
        for (int i = 0; i < 12; i++)
            random_request();
    endtask

    // Random traffic across several idling profiles
    task automatic test_random_requests();
        int gap_set [4]   = '{0, 3, 8, 2};
        int stall_set [4] = '{0, 30, 60, 10};
        int run_set [4]   = '{1, 4, 8, 2};
        for (int ph = 0; ph < 4; ph++)
        begin
            max_gap       = gap_set[ph];
            stall_pct     = stall_set[ph];
            stall_run_max = run_set[ph];
            for (int i = 0; i < 56; i++)
                random_request();
        end
    endtask

    // Receiver stall: runs of random length, plus the long hold-off
    initial
    begin
        int run_left;
        bit stall_now;
        run_left  = 0;
        stall_now = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_cycles > 0)
            begin
                out_stall <= 1'b1;
                holdoff_cycles--;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stall_now = ($urandom_range(0, 99) < stall_pct);
                    run_left  = $urandom_range(1, stall_run_max);
                end
                run_left--;
                out_stall <= stall_now;
            end
        end
    end

    // Byte checker: every accepted byte against the oldest expected one
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected byte %h end=%b last=%b trk=%0d vol=%0d",
                         $time, tx_byte, frame_end, last, track_now, volume_now);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if ({tx_byte, frame_end, last, track_now, volume_now} !==
                    {want.data, want.fend, want.lst, want.trk, want.vol})
                begin
                    errors++;
                    $display({"%0t: mismatch expected byte=%h end=%b last=%b ",
                              "trk=%0d vol=%0d, actual byte=%h end=%b last=%b ",
                              "trk=%0d vol=%0d"},
                             $time, want.data, want.fend, want.lst, want.trk,
                             want.vol, tx_byte, frame_end, last, track_now,
                             volume_now);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        int waited;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        req_type       = REQ_INIT;
        track_number   = 8'd0;
        volume_level   = 8'd0;
        pl_track       = 4'd0;
        pl_volume      = 5'd0;
        pl_stopped     = 1'b0;
        pl_resume      = 4'd0;
        errors         = 0;
        burst_left     = 0;
        max_gap        = 0;
        stall_pct      = 0;
        stall_run_max  = 1;
        holdoff_cycles = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_requests();
        test_output_holdoff();
        test_random_requests();

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then give the block time to show any stray byte
        waited = 0;
        while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_bytes.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected bytes never arrived", $time, pending_bytes.size());
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
